// ----- src/i2cm_pkg.sv -----
package i2cm_pkg;

    // Tick counter width default, configuration port geometry and queue depth
    localparam int TICK_COUNT_WIDTH_DEF = 16;
    localparam int CFG_DATA_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH      = 2;
    localparam int QUEUE_DEPTH          = 2;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BIT_HALF_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_STOP_HOLD = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACK_HALF_PERIOD = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACK_TIMEOUT     = 2'd3;

    // Register reset values
    localparam logic [15:0] BIT_HALF_PERIOD_RST = 16'd250;
    localparam logic [15:0] START_STOP_HOLD_RST = 16'd100;
    localparam logic [15:0] ACK_HALF_PERIOD_RST = 16'd200;
    localparam logic [7:0]  ACK_TIMEOUT_RST     = 8'd250;

    // Op codes on the input channel
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Classified command as held in the queue
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef enum logic [15:0] {
        PH_IDLE  = 16'b0000_0000_0000_0001,
        PH_ST_A  = 16'b0000_0000_0000_0010,
        PH_ST_B  = 16'b0000_0000_0000_0100,
        PH_FIN   = 16'b0000_0000_0000_1000,
        PH_SP_A  = 16'b0000_0000_0001_0000,
        PH_SP_B  = 16'b0000_0000_0010_0000,
        PH_WR_L1 = 16'b0000_0000_0100_0000,
        PH_WR_H  = 16'b0000_0000_1000_0000,
        PH_WR_L2 = 16'b0000_0001_0000_0000,
        PH_WA_L  = 16'b0000_0010_0000_0000,
        PH_WA_H  = 16'b0000_0100_0000_0000,
        PH_WA_P  = 16'b0000_1000_0000_0000,
        PH_RD_L  = 16'b0001_0000_0000_0000,
        PH_RD_H  = 16'b0010_0000_0000_0000,
        PH_AK_L  = 16'b0100_0000_0000_0000,
        PH_AK_H  = 16'b1000_0000_0000_0000
    } phase_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drv;
    } lines_t;

    localparam lines_t LV_HIGH_DRV  = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
    localparam lines_t LV_START_LOW = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
    localparam lines_t LV_BOTH_LOW  = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
    localparam lines_t LV_REL_LOW   = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
    localparam lines_t LV_REL_HIGH  = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } i2cm_in_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } i2cm_out_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } i2cm_qitem_t;

endpackage

// ----- src/i2cm_front.sv -----
module i2cm_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  i2cm_pkg::i2cm_in_t    s_data,
    output logic                  q_valid,
    input  logic                  q_ready,
    output i2cm_pkg::i2cm_qitem_t q_item
);

    localparam int PTR_W = $clog2(i2cm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(i2cm_pkg::QUEUE_DEPTH + 1);

    i2cm_pkg::i2cm_qitem_t mem [i2cm_pkg::QUEUE_DEPTH];
    i2cm_pkg::i2cm_qitem_t item_in;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push, pop;

    // Classify: undefined op codes collapse to no command
    always_comb begin
        item_in.tx_byte  = s_data.tx_byte;
        item_in.send_ack = s_data.send_ack;
        item_in.sda_in   = s_data.sda_in;
        case (s_data.op)
            i2cm_pkg::OP_START: item_in.cmd = i2cm_pkg::CMD_START;
            i2cm_pkg::OP_STOP:  item_in.cmd = i2cm_pkg::CMD_STOP;
            i2cm_pkg::OP_WRITE: item_in.cmd = i2cm_pkg::CMD_WRITE;
            i2cm_pkg::OP_READ:  item_in.cmd = i2cm_pkg::CMD_READ;
            default:            item_in.cmd = i2cm_pkg::CMD_NONE;
        endcase
    end

    assign s_ready = (count_reg != CNT_W'(i2cm_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(i2cm_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(i2cm_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ----- src/i2cm_back.sv -----
module i2cm_back #(
    parameter int TICK_COUNT_WIDTH = i2cm_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata,
    input  logic                                  q_valid,
    output logic                                  q_ready,
    input  i2cm_pkg::i2cm_qitem_t                 q_item,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output i2cm_pkg::i2cm_out_t                   m_data
);

    localparam int TW = TICK_COUNT_WIDTH;
    localparam int CW = ((TW > 16) ? TW : 16) + 1;

    logic [15:0] bit_half_reg, hold_reg, ack_half_reg;
    logic [7:0]  ack_timeout_reg;

    i2cm_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [TW-1:0] tc_reg, tc_next, tc_cur, tc_step;
    logic [7:0]    shift_reg, shift_next, shift_pick;
    logic [3:0]    bidx_reg, bidx_next, bidx_pick, bidx_inc;
    logic [7:0]    wait_reg, wait_next, wait_pick;
    logic          choice_reg, choice_next, choice_pick;
    logic          ack_err_reg, ack_err_next, ack_err_pick;
    logic [7:0]    rx_reg, rx_next;
    i2cm_pkg::lines_t lines_reg, lines_next, lv, fin_lv;
    logic          busy, done, to_fin, bit7, sdone;
    logic [15:0]   seg_len;
    logic [CW-1:0] eff_len;
    logic          fire;
    logic          m_valid_reg;
    i2cm_pkg::i2cm_out_t m_data_reg;

    assign fire    = q_valid && (!m_valid_reg || m_ready);
    assign q_ready = fire;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign bidx_inc = bidx_reg + 4'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_half_reg    <= i2cm_pkg::BIT_HALF_PERIOD_RST;
            hold_reg        <= i2cm_pkg::START_STOP_HOLD_RST;
            ack_half_reg    <= i2cm_pkg::ACK_HALF_PERIOD_RST;
            ack_timeout_reg <= i2cm_pkg::ACK_TIMEOUT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                i2cm_pkg::REG_BIT_HALF_PERIOD: bit_half_reg    <= cfg_wdata;
                i2cm_pkg::REG_START_STOP_HOLD: hold_reg        <= cfg_wdata;
                i2cm_pkg::REG_ACK_HALF_PERIOD: ack_half_reg    <= cfg_wdata;
                i2cm_pkg::REG_ACK_TIMEOUT:     ack_timeout_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Command pickup in idle: the effective phase of this tick
    always_comb begin
        phase_eff    = phase_reg;
        tc_cur       = tc_reg;
        shift_pick   = shift_reg;
        bidx_pick    = bidx_reg;
        wait_pick    = wait_reg;
        choice_pick  = choice_reg;
        ack_err_pick = ack_err_reg;
        busy         = 1'b1;
        if (phase_reg == i2cm_pkg::PH_IDLE) begin
            tc_cur = '0;
            case (q_item.cmd)
                i2cm_pkg::CMD_START: phase_eff = i2cm_pkg::PH_ST_A;
                i2cm_pkg::CMD_STOP:  phase_eff = i2cm_pkg::PH_SP_A;
                i2cm_pkg::CMD_WRITE: begin
                    shift_pick   = q_item.tx_byte;
                    bidx_pick    = '0;
                    wait_pick    = '0;
                    ack_err_pick = 1'b0;
                    phase_eff    = i2cm_pkg::PH_WR_L1;
                end
                i2cm_pkg::CMD_READ: begin
                    shift_pick  = '0;
                    bidx_pick   = '0;
                    choice_pick = q_item.send_ack;
                    phase_eff   = i2cm_pkg::PH_RD_L;
                end
                default: busy = 1'b0;
            endcase
        end
    end

    // Segment timer: length by phase, zero counts as one tick
    always_comb begin
        case (phase_eff)
            i2cm_pkg::PH_WR_L1, i2cm_pkg::PH_WR_H, i2cm_pkg::PH_WR_L2,
            i2cm_pkg::PH_RD_L,  i2cm_pkg::PH_RD_H:  seg_len = bit_half_reg;
            i2cm_pkg::PH_AK_L,  i2cm_pkg::PH_AK_H:  seg_len = ack_half_reg;
            default:                                seg_len = hold_reg;
        endcase
        eff_len = (seg_len == '0) ? CW'(1) : CW'(seg_len);
        sdone   = ((CW'(tc_cur) + CW'(1)) >= eff_len) || (&tc_cur);
        tc_step = sdone ? '0 : tc_cur + TW'(1);
    end

    always_comb begin
        phase_next   = phase_eff;
        tc_next      = tc_cur;
        shift_next   = shift_pick;
        bidx_next    = bidx_pick;
        wait_next    = wait_pick;
        choice_next  = choice_pick;
        ack_err_next = ack_err_pick;
        rx_next      = rx_reg;
        done         = 1'b0;
        to_fin       = 1'b0;
        fin_lv       = lines_reg;
        lv           = lines_reg;
        bit7         = shift_pick[7];
        case (phase_eff)
            i2cm_pkg::PH_ST_A: begin
                lv = i2cm_pkg::LV_HIGH_DRV;
                tc_next = tc_step;
                if (sdone) phase_next = i2cm_pkg::PH_ST_B;
            end
            i2cm_pkg::PH_ST_B: begin
                lv = i2cm_pkg::LV_START_LOW;
                tc_next = tc_step;
                if (sdone) begin
                    to_fin = 1'b1;
                    fin_lv = i2cm_pkg::LV_BOTH_LOW;
                end
            end
            i2cm_pkg::PH_FIN: begin
                done = 1'b1;
                phase_next = i2cm_pkg::PH_IDLE;
            end
            i2cm_pkg::PH_SP_A: begin
                lv = i2cm_pkg::LV_BOTH_LOW;
                tc_next = tc_step;
                if (sdone) phase_next = i2cm_pkg::PH_SP_B;
            end
            i2cm_pkg::PH_SP_B: begin
                lv = i2cm_pkg::LV_HIGH_DRV;
                tc_next = tc_step;
                if (sdone) begin
                    done = 1'b1;
                    phase_next = i2cm_pkg::PH_IDLE;
                end
            end
            i2cm_pkg::PH_WR_L1: begin
                lv = '{scl: 1'b0, sda: bit7, drv: 1'b1};
                tc_next = tc_step;
                if (sdone) phase_next = i2cm_pkg::PH_WR_H;
            end
            i2cm_pkg::PH_WR_H: begin
                lv = '{scl: 1'b1, sda: bit7, drv: 1'b1};
                tc_next = tc_step;
                if (sdone) phase_next = i2cm_pkg::PH_WR_L2;
            end
            i2cm_pkg::PH_WR_L2: begin
                lv = '{scl: 1'b0, sda: bit7, drv: 1'b1};
                tc_next = tc_step;
                if (sdone) begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bidx_next  = bidx_inc;
                    phase_next = (bidx_inc >= 4'd8) ? i2cm_pkg::PH_WA_L : i2cm_pkg::PH_WR_L1;
                end
            end
            i2cm_pkg::PH_WA_L: begin
                lv = i2cm_pkg::LV_REL_LOW;
                tc_next = tc_step;
                if (sdone) phase_next = i2cm_pkg::PH_WA_H;
            end
            i2cm_pkg::PH_WA_H: begin
                lv = i2cm_pkg::LV_REL_HIGH;
                tc_next = tc_step;
                if (sdone) begin
                    phase_next = i2cm_pkg::PH_WA_P;
                    wait_next  = '0;
                end
            end
            i2cm_pkg::PH_WA_P: begin
                lv = i2cm_pkg::LV_REL_HIGH;
                if (!q_item.sda_in) begin
                    to_fin = 1'b1;
                    fin_lv = i2cm_pkg::LV_REL_LOW;
                end else if (wait_reg >= ack_timeout_reg) begin
                    // no acknowledge in time: flag and run a stop
                    ack_err_next = 1'b1;
                    tc_next      = '0;
                    phase_next   = i2cm_pkg::PH_SP_A;
                end else begin
                    wait_next = wait_reg + 8'd1;
                end
            end
            i2cm_pkg::PH_RD_L: begin
                lv = i2cm_pkg::LV_REL_LOW;
                tc_next = tc_step;
                if (sdone) phase_next = i2cm_pkg::PH_RD_H;
            end
            i2cm_pkg::PH_RD_H: begin
                lv = i2cm_pkg::LV_REL_HIGH;
                // sample on the first tick of SCL high
                if (tc_cur == '0) shift_next = {shift_reg[6:0], q_item.sda_in};
                tc_next = tc_step;
                if (sdone) begin
                    bidx_next  = bidx_inc;
                    phase_next = (bidx_inc >= 4'd8) ? i2cm_pkg::PH_AK_L : i2cm_pkg::PH_RD_L;
                end
            end
            i2cm_pkg::PH_AK_L: begin
                lv = '{scl: 1'b0, sda: ~choice_reg, drv: 1'b1};
                tc_next = tc_step;
                if (sdone) phase_next = i2cm_pkg::PH_AK_H;
            end
            i2cm_pkg::PH_AK_H: begin
                lv = '{scl: 1'b1, sda: ~choice_reg, drv: 1'b1};
                tc_next = tc_step;
                if (sdone) begin
                    rx_next = shift_reg;
                    to_fin  = 1'b1;
                    fin_lv  = '{scl: 1'b0, sda: ~choice_reg, drv: 1'b1};
                end
            end
            default: lv = lines_reg;
        endcase
        lines_next = lv;
        if (to_fin) begin
            lines_next = fin_lv;
            phase_next = i2cm_pkg::PH_FIN;
            tc_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= i2cm_pkg::PH_IDLE;
            tc_reg      <= '0;
            shift_reg   <= '0;
            bidx_reg    <= '0;
            wait_reg    <= '0;
            choice_reg  <= 1'b0;
            ack_err_reg <= 1'b0;
            rx_reg      <= '0;
            lines_reg   <= i2cm_pkg::LV_HIGH_DRV;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg   <= phase_next;
                tc_reg      <= tc_next;
                shift_reg   <= shift_next;
                bidx_reg    <= bidx_next;
                wait_reg    <= wait_next;
                choice_reg  <= choice_next;
                ack_err_reg <= ack_err_next;
                rx_reg      <= rx_next;
                lines_reg   <= lines_next;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg.scl_out   <= lv.scl;
            m_data_reg.sda_out   <= lv.sda;
            m_data_reg.sda_drive <= lv.drv;
            m_data_reg.busy_res  <= busy;
            m_data_reg.done_res  <= done;
            m_data_reg.rx_byte   <= rx_next;
            m_data_reg.ack_error <= ack_err_next;
        end
    end

endmodule

// ----- src/i2c_master_byte_engine_unit.sv -----
// I2C master bit engine, stepped one item per tick. Each input item is one tick:
// it may carry a command (start, stop, write byte, read byte; other op codes act
// as none), the byte to send, the ACK/NACK choice for a read and the sampled SDA
// level, and it yields exactly one result item with the SCL/SDA levels, SDA drive
// enable, busy and done flags, the last read byte and the acknowledge error flag.
// Commands arriving while a command runs are ignored. Rate: one item per clock
// cycle while the result is not stalled; an accepted item is held in the input
// queue, and the engine takes it from the head and registers its result. A
// stalled result holds the engine; the input stalls once the two-entry queue is
// full. The engine state is updated once per accepted item, so every tick
// depends only on the last.
// Segment lengths come from four registers written through cfg_we/cfg_index/
// cfg_wdata: 0 bit half period, 1 start/stop hold, 2 ack half period,
// 3 acknowledge timeout (8 bits). The user must write them only while idle;
// the block does not enforce it. TICK_COUNT_WIDTH sizes the segment counter;
// segments longer than 2**TICK_COUNT_WIDTH ticks are cut to that length.
module i2c_master_byte_engine_unit #(
    parameter int TICK_COUNT_WIDTH = i2cm_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  i2cm_pkg::i2cm_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output i2cm_pkg::i2cm_out_t                  m_data
);

    // Queue between the classifying front and the bit engine
    logic                  q_valid;
    logic                  q_ready;
    i2cm_pkg::i2cm_qitem_t q_item;

    // Front: accept items, decode op codes, hold them in a short queue
    i2cm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // Back: advance the engine one tick per item, register the result
    i2cm_back #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- src/i2cm_checker.sv -----
module i2cm_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input i2cm_pkg::i2cm_out_t                  m_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A command finishes only while busy
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> m_data.busy_res)
        else $error("done without busy");

    // Released SDA always reads as high level
    a_release_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.sda_drive |-> m_data.sda_out)
        else $error("sda low while released");

    // Input side is open straight after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("not ready after reset");

endmodule

bind i2c_master_byte_engine_unit i2cm_checker u_checker (.*);
